>>> src/sic_pkg.sv
// sic_pkg: shared constants and sizing helpers for the segment intersection core.
// No dependencies.
package sic_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int OUT_BITS       = 32;
  localparam int QUEUE_DEPTH    = 4;

  // Width of one classified item between front and back:
  // found, neg_x, neg_y, base_x, base_y, n, d, ax, ay.
  function automatic int item_bits(input int coord_bits);
    return 3 + 4 * coord_bits + 2 * (2 * coord_bits + 2);
  endfunction

endpackage

>>> src/sic_front.sv
// sic_front: three-stage front end; differences, cross products, side tests.
// Depends on sic_pkg.
module sic_front #(
  parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              in_vld,
  output logic                                              in_rdy,
  input  logic signed [COORD_BITS-1:0]                      a1_x,
  input  logic signed [COORD_BITS-1:0]                      a1_y,
  input  logic signed [COORD_BITS-1:0]                      a2_x,
  input  logic signed [COORD_BITS-1:0]                      a2_y,
  input  logic signed [COORD_BITS-1:0]                      b1_x,
  input  logic signed [COORD_BITS-1:0]                      b1_y,
  input  logic signed [COORD_BITS-1:0]                      b2_x,
  input  logic signed [COORD_BITS-1:0]                      b2_y,
  output logic                                              itm_vld,
  input  logic                                              itm_rdy,
  output logic [sic_pkg::item_bits(COORD_BITS)-1:0]          itm
);
  import sic_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int DW  = C + 1;
  localparam int PRW = 2 * DW;
  localparam int XW  = PRW + 1;
  localparam int NW  = 2 * C + 2;

  typedef struct packed {
    logic                found;
    logic                neg_x;
    logic                neg_y;
    logic signed [C-1:0] base_x;
    logic signed [C-1:0] base_y;
    logic [NW-1:0]       n;
    logic [NW-1:0]       d;
    logic [C-1:0]        ax;
    logic [C-1:0]        ay;
  } item_t;

  logic en;
  logic v1_r, v2_r, v3_r;

  // stage 1: differences
  logic signed [DW-1:0] adx_r, ady_r, bdx_r, bdy_r;
  logic signed [DW-1:0] ux_r, uy_r, vx_r, vy_r, wx_r, wy_r, zx_r, zy_r;
  logic signed [C-1:0]  a1x1_r, a1y1_r;
  // stage 2: products
  logic signed [PRW-1:0] p_r [12];
  logic signed [C-1:0]   a1x2_r, a1y2_r;
  logic signed [DW-1:0]  adx2_r, ady2_r;
  // stage 3: classified item
  item_t itm_r, itm_nxt;

  logic signed [XW-1:0] c [6];
  logic                 pos [6];
  logic                 neg [6];
  logic                 hit;

  assign en     = !v3_r || itm_rdy;
  assign in_rdy = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adx_r  <= DW'(a2_x) - DW'(a1_x);
      ady_r  <= DW'(a2_y) - DW'(a1_y);
      bdx_r  <= DW'(b2_x) - DW'(b1_x);
      bdy_r  <= DW'(b2_y) - DW'(b1_y);
      ux_r   <= DW'(b1_x) - DW'(a1_x);
      uy_r   <= DW'(b1_y) - DW'(a1_y);
      vx_r   <= DW'(b2_x) - DW'(a1_x);
      vy_r   <= DW'(b2_y) - DW'(a1_y);
      wx_r   <= DW'(a1_x) - DW'(b1_x);
      wy_r   <= DW'(a1_y) - DW'(b1_y);
      zx_r   <= DW'(a2_x) - DW'(b1_x);
      zy_r   <= DW'(a2_y) - DW'(b1_y);
      a1x1_r <= a1_x;
      a1y1_r <= a1_y;

      p_r[0]  <= PRW'(adx_r) * PRW'(uy_r);
      p_r[1]  <= PRW'(ady_r) * PRW'(ux_r);
      p_r[2]  <= PRW'(adx_r) * PRW'(vy_r);
      p_r[3]  <= PRW'(ady_r) * PRW'(vx_r);
      p_r[4]  <= PRW'(bdx_r) * PRW'(wy_r);
      p_r[5]  <= PRW'(bdy_r) * PRW'(wx_r);
      p_r[6]  <= PRW'(bdx_r) * PRW'(zy_r);
      p_r[7]  <= PRW'(bdy_r) * PRW'(zx_r);
      p_r[8]  <= PRW'(adx_r) * PRW'(bdy_r);
      p_r[9]  <= PRW'(ady_r) * PRW'(bdx_r);
      p_r[10] <= PRW'(ux_r) * PRW'(bdy_r);
      p_r[11] <= PRW'(uy_r) * PRW'(bdx_r);
      a1x2_r  <= a1x1_r;
      a1y2_r  <= a1y1_r;
      adx2_r  <= adx_r;
      ady2_r  <= ady_r;

      itm_r <= itm_nxt;
    end
  end

  // c[0..3]: sides of b1, b2, a1, a2; c[4]: denominator; c[5]: numerator
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      c[k]   = XW'(p_r[2*k]) - XW'(p_r[2*k+1]);
      neg[k] = c[k][XW-1];
      pos[k] = !c[k][XW-1] && (c[k] != '0);
    end
    hit = ((pos[0] && neg[1]) || (neg[0] && pos[1])) &&
          ((pos[2] && neg[3]) || (neg[2] && pos[3])) && (c[4] != '0);

    itm_nxt = '0;
    itm_nxt.found = hit;
    itm_nxt.d     = NW'(1);
    if (hit) begin
      itm_nxt.neg_x  = neg[5] ^ neg[4] ^ adx2_r[DW-1];
      itm_nxt.neg_y  = neg[5] ^ neg[4] ^ ady2_r[DW-1];
      itm_nxt.base_x = a1x2_r;
      itm_nxt.base_y = a1y2_r;
      itm_nxt.n      = neg[5] ? NW'(-c[5]) : NW'(c[5]);
      itm_nxt.d      = neg[4] ? NW'(-c[4]) : NW'(c[4]);
      itm_nxt.ax     = adx2_r[DW-1] ? C'(-adx2_r) : C'(adx2_r);
      itm_nxt.ay     = ady2_r[DW-1] ? C'(-ady2_r) : C'(ady2_r);
    end
  end

  assign itm_vld = v3_r;
  assign itm     = itm_r;

endmodule

>>> src/sic_queue.sv
// sic_queue: small register FIFO decoupling front and back.
// Depends on sic_pkg.
module sic_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sic_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  output logic             in_rdy,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_vld,
  input  logic             out_rdy,
  output logic [WIDTH-1:0] out_data
);
  import sic_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             push, pop;

  assign in_rdy   = (cnt_r != CW'(DEPTH));
  assign out_vld  = (cnt_r != '0);
  assign push     = in_vld && in_rdy;
  assign pop      = out_vld && out_rdy;
  assign out_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> src/sic_back.sv
// sic_back: multiply stage, pipelined restoring divider, output register.
// Depends on sic_pkg.
module sic_back #(
  parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sic_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      itm_vld,
  output logic                                      itm_rdy,
  input  logic [sic_pkg::item_bits(COORD_BITS)-1:0]  itm,
  output logic                                      out_vld,
  input  logic                                      out_rdy,
  output logic                                      found,
  output logic signed [sic_pkg::OUT_BITS-1:0]        cross_x,
  output logic signed [sic_pkg::OUT_BITS-1:0]        cross_y
);
  import sic_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int NW  = 2 * C + 2;
  localparam int PPW = NW + C;
  localparam int PW  = PPW + F;
  localparam int QW  = C + F;
  localparam int RW  = C + F + 2;

  typedef struct packed {
    logic                found;
    logic                neg_x;
    logic                neg_y;
    logic signed [C-1:0] base_x;
    logic signed [C-1:0] base_y;
    logic [NW-1:0]       n;
    logic [NW-1:0]       d;
    logic [C-1:0]        ax;
    logic [C-1:0]        ay;
  } item_t;

  typedef struct packed {
    logic                found;
    logic                neg_x;
    logic                neg_y;
    logic signed [C-1:0] base_x;
    logic signed [C-1:0] base_y;
    logic [NW-1:0]       d;
    logic [NW-1:0]       rx;
    logic [NW-1:0]       ry;
    logic [QW-1:0]       wx;
    logic [QW-1:0]       wy;
  } div_t;

  item_t           it;
  logic            en;
  logic            m_vld_r;
  item_t           m_r;
  logic [PPW-1:0]  px_r, py_r;
  logic [PW-1:0]   pwx, pwy;
  logic            dv_r [QW+1];
  div_t            ds_r [QW+1];
  logic            o_vld_r;
  logic            o_found_r;
  logic signed [OUT_BITS-1:0] o_x_r, o_y_r;
  logic signed [RW-1:0] sx, sy;

  assign it      = item_t'(itm);
  assign en      = !o_vld_r || out_rdy;
  assign itm_rdy = en;

  always_ff @(posedge clk) begin
    if (!rst_n) m_vld_r <= 1'b0;
    else if (en) m_vld_r <= itm_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r  <= it;
      px_r <= PPW'(it.n) * PPW'(it.ax);
      py_r <= PPW'(it.n) * PPW'(it.ay);
    end
  end

  assign pwx = PW'(px_r) << F;
  assign pwy = PW'(py_r) << F;

  // divider head: high part of the dividend is known below d
  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else if (en) dv_r[0] <= m_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds_r[0].found  <= m_r.found;
      ds_r[0].neg_x  <= m_r.neg_x;
      ds_r[0].neg_y  <= m_r.neg_y;
      ds_r[0].base_x <= m_r.base_x;
      ds_r[0].base_y <= m_r.base_y;
      ds_r[0].d      <= m_r.d;
      ds_r[0].rx     <= NW'(pwx >> QW);
      ds_r[0].ry     <= NW'(pwy >> QW);
      ds_r[0].wx     <= pwx[QW-1:0];
      ds_r[0].wy     <= pwy[QW-1:0];
    end
  end

  // one quotient bit per stage; w shifts dividend bits out, quotient bits in
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [NW:0] tx, ty, dd;
    logic        gx, gy;
    div_t        nx;

    always_comb begin
      dd = {1'b0, ds_r[k].d};
      tx = {ds_r[k].rx, ds_r[k].wx[QW-1]};
      ty = {ds_r[k].ry, ds_r[k].wy[QW-1]};
      gx = (tx >= dd);
      gy = (ty >= dd);
      nx    = ds_r[k];
      nx.rx = gx ? NW'(tx - dd) : NW'(tx);
      nx.ry = gy ? NW'(ty - dd) : NW'(ty);
      nx.wx = {ds_r[k].wx[QW-2:0], gx};
      nx.wy = {ds_r[k].wy[QW-2:0], gy};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1] <= 1'b0;
      else if (en) dv_r[k+1] <= dv_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) ds_r[k+1] <= nx;
    end
  end

  always_comb begin
    sx = (RW'(ds_r[QW].base_x) <<< F);
    sy = (RW'(ds_r[QW].base_y) <<< F);
    sx = ds_r[QW].neg_x ? sx - RW'(ds_r[QW].wx) : sx + RW'(ds_r[QW].wx);
    sy = ds_r[QW].neg_y ? sy - RW'(ds_r[QW].wy) : sy + RW'(ds_r[QW].wy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else if (en) o_vld_r <= dv_r[QW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_found_r <= ds_r[QW].found;
      o_x_r     <= OUT_BITS'(sx);
      o_y_r     <= OUT_BITS'(sy);
    end
  end

  assign out_vld = o_vld_r;
  assign found   = o_found_r;
  assign cross_x = o_x_r;
  assign cross_y = o_y_r;

endmodule

>>> src/segment_intersection_core.sv
// From input beat to result beat: three front stages, queue, multiply,
// divider head, one divider stage per quotient bit, output register.
// Throughput: one beat per cycle while out_ready stays high; the divider is
// fully pipelined.
// Reset: synchronous, active low; clears all valid flags and the queue pointers and count.
// Front stalls only when the 4-entry queue is full; back stalls on out_ready.
//
// Structure:
//   sic_front  - coordinate differences, twelve products, side tests and
//                sign/magnitude split of numerator and denominator.
//   sic_queue  - register FIFO so front and back can stall independently.
//   sic_back   - |num| * |delta|, then restoring division by |den| one bit a
//                stage, then a1 * 2^FRAC_BITS +/- quotient, truncated to 32 bits.
// Pairs that do not strictly cross flow through with zero numerator and a unit
// divisor, so they come out as found = 0 with zero coordinates.
module segment_intersection_core #(
  parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sic_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_BITS-1:0]         in_a1_x,
  input  logic signed [COORD_BITS-1:0]         in_a1_y,
  input  logic signed [COORD_BITS-1:0]         in_a2_x,
  input  logic signed [COORD_BITS-1:0]         in_a2_y,
  input  logic signed [COORD_BITS-1:0]         in_b1_x,
  input  logic signed [COORD_BITS-1:0]         in_b1_y,
  input  logic signed [COORD_BITS-1:0]         in_b2_x,
  input  logic signed [COORD_BITS-1:0]         in_b2_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_found,
  output logic signed [sic_pkg::OUT_BITS-1:0]  out_cross_x,
  output logic signed [sic_pkg::OUT_BITS-1:0]  out_cross_y
);
  import sic_pkg::*;

  localparam int IW = item_bits(COORD_BITS);

  logic          f_vld, f_rdy;
  logic [IW-1:0] f_itm;
  logic          b_vld, b_rdy;
  logic [IW-1:0] b_itm;

  sic_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_valid),
    .in_rdy  (in_ready),
    .a1_x    (in_a1_x),
    .a1_y    (in_a1_y),
    .a2_x    (in_a2_x),
    .a2_y    (in_a2_y),
    .b1_x    (in_b1_x),
    .b1_y    (in_b1_y),
    .b2_x    (in_b2_x),
    .b2_y    (in_b2_y),
    .itm_vld (f_vld),
    .itm_rdy (f_rdy),
    .itm     (f_itm)
  );

  sic_queue #(
    .WIDTH(IW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (f_vld),
    .in_rdy   (f_rdy),
    .in_data  (f_itm),
    .out_vld  (b_vld),
    .out_rdy  (b_rdy),
    .out_data (b_itm)
  );

  sic_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .itm_vld (b_vld),
    .itm_rdy (b_rdy),
    .itm     (b_itm),
    .out_vld (out_valid),
    .out_rdy (out_ready),
    .found   (out_found),
    .cross_x (out_cross_x),
    .cross_y (out_cross_y)
  );

endmodule

>>> src/sic_checker.sv
// sic_checker: port-level assertions for segment_intersection_core, plus bind.
// Depends on sic_pkg.
module sic_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_found,
  input logic signed [sic_pkg::OUT_BITS-1:0] out_cross_x,
  input logic signed [sic_pkg::OUT_BITS-1:0] out_cross_y
);
  import sic_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
      $stable(out_cross_x) && $stable(out_cross_y))
    else $error("result beat changed while stalled");

  // no crossing means zero coordinates
  a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_cross_x == '0 && out_cross_y == '0)
    else $error("nonzero point without crossing");

  // pipeline is empty right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind segment_intersection_core sic_checker u_sic_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_found   (out_found),
  .out_cross_x (out_cross_x),
  .out_cross_y (out_cross_y)
);

>>> verif/tb_segment_intersection_core.sv
// Testbench for segment_intersection_core: directed and random segment pairs,
// with a self-contained crossing predictor and an in-order result scoreboard.
// Depends on sic_pkg and segment_intersection_core.
module tb_segment_intersection_core;
  import sic_pkg::*;

  localparam int CB       = COORD_BITS_DEF;
  localparam int FB       = FRAC_BITS_DEF;
  localparam int LATENCY  = CB + FB + 7;
  localparam int STALL_MAX = 4000;  // cycles without any beat before giving up
  localparam int N_RANDOM = 1430;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct {
    coord_t a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
  } seg_pair_t;
  typedef struct {
    logic found;
    logic signed [OUT_BITS-1:0] px, py;
  } hit_t;

  // Orientation sign of (u x v).
  function automatic int orient(longint ux, longint uy, longint vx, longint vy);
    longint c;
    c = ux * vy - uy * vx;
    return (c > 0) - (c < 0);
  endfunction

  // base * 2^FB plus |num*delta/den| with the pair's sign, truncated toward zero.
  function automatic longint lerp_fixed(longint base, longint delta, longint num, longint den);
    bit [127:0] prod, q;
    longint an, ad, adelta, off;
    int s;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    adelta = (delta < 0) ? -delta : delta;
    prod = 128'(an) * (128'(adelta) << FB);
    q = prod / 128'(ad);
    off = longint'(q[63:0]);
    s = ((num > 0) - (num < 0)) * ((delta > 0) - (delta < 0)) * ((den > 0) - (den < 0));
    return base * (longint'(1) << FB) + ((s < 0) ? -off : off);
  endfunction

  function automatic hit_t predict_crossing(seg_pair_t p);
    hit_t r;
    longint a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y, adx, ady, bdx, bdy, den, num, x, y;
    int sb1, sb2, sa1, sa2;
    a1x = longint'(p.a1x); a1y = longint'(p.a1y);
    a2x = longint'(p.a2x); a2y = longint'(p.a2y);
    b1x = longint'(p.b1x); b1y = longint'(p.b1y);
    b2x = longint'(p.b2x); b2y = longint'(p.b2y);
    adx = a2x - a1x; ady = a2y - a1y;
    bdx = b2x - b1x; bdy = b2y - b1y;
    sb1 = orient(adx, ady, b1x - a1x, b1y - a1y);
    sb2 = orient(adx, ady, b2x - a1x, b2y - a1y);
    sa1 = orient(bdx, bdy, a1x - b1x, a1y - b1y);
    sa2 = orient(bdx, bdy, a2x - b1x, a2y - b1y);
    den = adx * bdy - ady * bdx;
    r.found = (sb1 * sb2 < 0) && (sa1 * sa2 < 0) && (den != 0);
    r.px = '0;
    r.py = '0;
    if (r.found) begin
      num = (b1x - a1x) * bdy - (b1y - a1y) * bdx;
      x = lerp_fixed(a1x, adx, num, den);
      y = lerp_fixed(a1y, ady, num, den);
      r.px = x[OUT_BITS-1:0];
      r.py = y[OUT_BITS-1:0];
    end
    return r;
  endfunction

  class crossing_scoreboard;
    hit_t pending[$];
    int errors = 0;

    function void note_pair(seg_pair_t p);
      pending.push_back(predict_crossing(p));
    endfunction

    function void check_hit(logic found, logic signed [OUT_BITS-1:0] px,
                            logic signed [OUT_BITS-1:0] py);
      hit_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing pending: found=%0d x=%0d y=%0d", found, px, py);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (found !== e.found) begin
        $error("found: expected %0d, got %0d", e.found, found);
        errors++;
      end
      if (px !== e.px) begin
        $error("cross_x: expected %0d, got %0d", e.px, px);
        errors++;
      end
      if (py !== e.py) begin
        $error("cross_y: expected %0d, got %0d", e.py, py);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t in_a1_x = '0, in_a1_y = '0, in_a2_x = '0, in_a2_y = '0;
  coord_t in_b1_x = '0, in_b1_y = '0, in_b2_x = '0, in_b2_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_found;
  logic signed [OUT_BITS-1:0] out_cross_x, out_cross_y;

  crossing_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  no_idle_send = 1'b0;   // long run with back-to-back beats
  bit  hold_off_rx  = 1'b0;   // receiver stalls hard to fill the pipe

  segment_intersection_core dut (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_a1_x, .in_a1_y, .in_a2_x, .in_a2_y,
    .in_b1_x, .in_b1_y, .in_b2_x, .in_b2_y,
    .out_valid, .out_ready, .out_found, .out_cross_x, .out_cross_y
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Present one pair at the falling edge and hold it until the beat lands.
  task automatic send_pair(seg_pair_t p);
    @(negedge clk);
    while (!no_idle_send && $urandom_range(99) < 28) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_a1_x = p.a1x; in_a1_y = p.a1y; in_a2_x = p.a2x; in_a2_y = p.a2y;
    in_b1_x = p.b1x; in_b1_y = p.b1y; in_b2_x = p.b2x; in_b2_y = p.b2y;
    do @(posedge clk); while (!in_ready);
    sb.note_pair(p);
  endtask

  function automatic seg_pair_t mk(int a1x, int a1y, int a2x, int a2y,
                                   int b1x, int b1y, int b2x, int b2y);
    seg_pair_t p;
    p.a1x = coord_t'(a1x); p.a1y = coord_t'(a1y);
    p.a2x = coord_t'(a2x); p.a2y = coord_t'(a2y);
    p.b1x = coord_t'(b1x); p.b1y = coord_t'(b1y);
    p.b2x = coord_t'(b2x); p.b2y = coord_t'(b2y);
    return p;
  endfunction

  function automatic int rnd_full();
    return int'($signed(16'($urandom)));
  endfunction

  function automatic int rnd_span(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  // Pair built around a common point: the two segments almost always cross.
  function automatic seg_pair_t rnd_crossing();
    int cx, cy, ux, uy, vx, vy;
    cx = rnd_span(16000); cy = rnd_span(16000);
    ux = rnd_span(16000); uy = rnd_span(16000);
    vx = rnd_span(16000); vy = rnd_span(16000);
    return mk(cx - ux, cy - uy, cx + (ux >>> $urandom_range(3)), cy + (uy >>> $urandom_range(3)),
              cx - vx, cy - vy, cx + (vx >>> $urandom_range(3)), cy + (vy >>> $urandom_range(3)));
  endfunction

  // Receiver: random backpressure, one long hold-off, an always-ready stretch late on.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_rx) begin
        out_ready = 1'b0;
      end else if (no_idle_send) begin
        out_ready = 1'b1;
      end else begin
        out_ready = ($urandom_range(99) >= 28);
      end
    end
  end

  // Check every result beat at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_hit(out_found, out_cross_x, out_cross_y);
    end
  end

  // Watchdog: count cycles where no beat moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int mx, mn;
    mx = 32767;
    mn = -32768;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed beats.
    send_pair(mk(0, 0, 10, 10, 0, 10, 10, 0));            // plain X, hits (5,5)
    send_pair(mk(0, 0, 3, 1, 1, 2, 2, -5));               // fractional point
    send_pair(mk(0, 0, 10, 0, 5, 0, 5, 10));              // endpoint touches a
    send_pair(mk(0, 0, 10, 0, 10, 0, 20, 5));             // shared endpoint
    send_pair(mk(0, 0, 10, 0, 2, 0, 20, 0));              // collinear overlap
    send_pair(mk(0, 0, 10, 0, 0, 5, 10, 5));              // parallel
    send_pair(mk(0, 0, 0, 0, -5, -5, 5, 5));              // degenerate a
    send_pair(mk(0, 0, 10, 0, 20, -5, 20, 5));            // line crosses, segment misses
    send_pair(mk(mn, mn, mx, mx, mn, mx, mx, mn));        // corner diagonals
    send_pair(mk(mx, mx, mn, mn, mx, mn, mn, mx));        // reversed direction
    send_pair(mk(mn, 0, mx, 0, 0, mn, 0, mx));            // axes at full span
    send_pair(mk(mx, -1, mn, 1, -1, mn, 1, mx));          // near-axis full span
    send_pair(mk(mn, mn, mx, mn + 1, mx, mn, mn, mn + 1)); // very flat pair
    send_pair(mk(mn, mx, mx, mn, mn, mn, mx, mx - 1));
    send_pair(mk(-1, -1, 1, 1, -1, 1, 1, -1));            // smallest crossing
    send_pair(mk(-7, 3, 5, -2, -1, -9, 2, 8));            // negative fractions
    send_pair(mk(mn, mn, mn, mn, mx, mx, mx, mx));        // points only
    send_pair(mk(-1, -1, -1, -1, -1, -1, -1, -1));        // all ones
    send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));                // all zeros

    // Random beats: mostly crossing pairs, the rest raw or small-grid noise.
    for (int i = 0; i < N_RANDOM; i++) begin
      int pick;
      seg_pair_t p;
      if (i == 300) begin
        // Receiver holds off while the sender keeps offering beats.
        hold_off_rx = 1'b1;
        fork
          begin
            repeat (300) @(posedge clk);
            hold_off_rx = 1'b0;
          end
        join_none
      end
      if (i == 600) begin
        // Sender pauses until the pipe has fully drained.
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      no_idle_send = (i >= 800 && i < 1000);
      pick = $urandom_range(99);
      if (pick < 60) begin
        p = rnd_crossing();
      end else if (pick < 80) begin
        p = mk(rnd_full(), rnd_full(), rnd_full(), rnd_full(),
               rnd_full(), rnd_full(), rnd_full(), rnd_full());
      end else begin
        p = mk(rnd_span(4), rnd_span(4), rnd_span(4), rnd_span(4),
               rnd_span(4), rnd_span(4), rnd_span(4), rnd_span(4));
      end
      send_pair(p);
    end
    @(negedge clk);
    in_valid = 1'b0;
    no_idle_send = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/sic_pkg.sv
src/sic_front.sv
src/sic_queue.sv
src/sic_back.sv
src/segment_intersection_core.sv
src/sic_checker.sv
verif/tb_segment_intersection_core.sv
